// ----- hw/rtl/sorted_priority_queue_defines.svh -----
// Assertion macros for the sorted priority queue RTL; spq_datapath includes them.
// Depends on nothing; files that assert take it by include.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check failed");

`endif

// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants of the sorted priority queue.
// Depends on nothing; used by every module of the block but spq_ram.
package spq_pkg;

    localparam int SPQ_DEPTH     = 16;
    localparam int SPQ_TAG_BITS  = 8;
    localparam int SPQ_PRIO_BITS = 8;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_POS
    } rd_src_t;

    typedef enum logic {
        WR_SHIFT,
        WR_NEW
    } wr_src_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_PUSH_INS,
        S_FRONT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load_in;
        rd_src_t rd_src;
        logic    wr_en;
        wr_src_t wr_src;
        logic    pos_dec;
        logic    count_inc;
        logic    pop_commit;
        logic    front_load;
        logic    out_load;
    } spq_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic goes_first;
        logic pos_one;
        logic act_pop;
        logic out_free;
    } spq_stat_t;

endpackage

// ----- hw/rtl/spq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/spq_ctrl.sv -----
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg; drives the datapath by command and reads its status.
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_PUSH)
                    begin
                        if (stat.count_full)
                        begin
                            state_next = S_DONE;
                        end
                        else if (stat.count_zero)
                        begin
                            state_next = S_PUSH_INS;
                        end
                        else
                        begin
                            state_next = S_PUSH_CMP;
                        end
                    end
                    else if ((action == ACT_POP || action == ACT_PEEK) && !stat.count_zero)
                    begin
                        state_next = S_FRONT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PUSH_RD:
            begin
                state_next = S_PUSH_CMP;
            end
            S_PUSH_CMP:
            begin
                if (stat.goes_first)
                begin
                    state_next = stat.pos_one ? S_PUSH_INS : S_PUSH_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PUSH_INS:
            begin
                state_next = S_DONE;
            end
            S_FRONT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd            = '0;
        cmd.rd_src     = RD_HEAD;
        cmd.wr_src     = WR_NEW;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = accept;
                cmd.rd_src  = (action == ACT_PUSH) ? RD_TAIL : RD_HEAD;
            end
            S_PUSH_RD:
            begin
                cmd.rd_src = RD_POS;
            end
            S_PUSH_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.goes_first)
                begin
                    cmd.wr_src  = WR_SHIFT;
                    cmd.pos_dec = 1'b1;
                end
                else
                begin
                    cmd.wr_src    = WR_NEW;
                    cmd.count_inc = 1'b1;
                end
            end
            S_PUSH_INS:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_src    = WR_NEW;
                cmd.count_inc = 1'b1;
            end
            S_FRONT:
            begin
                cmd.front_load = 1'b1;
                cmd.pop_commit = stat.act_pop;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.rd_src = RD_HEAD;
            end
        endcase
    end

endmodule

// ----- hw/rtl/spq_datapath.sv -----
// Datapath of the sorted priority queue: entry RAMs, pointers and result words.
// Depends on spq_pkg, spq_ram and sorted_priority_queue_defines.svh.
`include "sorted_priority_queue_defines.svh"
module spq_datapath #(
    parameter int DEPTH     = 16,
    parameter int TAG_BITS  = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            action,
    input  logic [TAG_BITS-1:0]   entry_tag,
    input  logic [PRIO_BITS-1:0]  entry_priority,
    input  logic                  cfg_valid,
    input  logic                  cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TAG_BITS-1:0]   front_tag,
    output logic [1:0]            status,
    input  spq_pkg::spq_cmd_t     cmd,
    output spq_pkg::spq_stat_t    stat
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Control state.
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic          asc_reg, asc_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state.
    logic [1:0]           action_reg, action_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [TAG_BITS-1:0]  res_tag_reg, res_tag_next;
    status_t              res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]  out_tag_reg, out_tag_next;
    status_t              out_status_reg, out_status_next;

    // RAM ports.
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [TAG_BITS-1:0]  wr_tag;
    logic [PRIO_BITS-1:0] wr_prio;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [PRIO_BITS-1:0] rd_prio;

    logic [AW-1:0] tail_idx;
    logic [AW-1:0] pos_m1;

    // Logical place to physical address in the circular store.
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                              input logic [AW-1:0] idx);
        logic [AW:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, idx};
            if (sum >= (AW+1)'(DEPTH))
            begin
                sum = sum - (AW+1)'(DEPTH);
            end
            to_phys = sum[AW-1:0];
        end
    endfunction

    assign tail_idx = AW'(count_reg - CW'(1));
    assign pos_m1   = pos_reg - AW'(1);

    always_comb
    begin
        case (cmd.rd_src)
            RD_HEAD: rd_addr = head_reg;
            RD_TAIL: rd_addr = to_phys(head_reg, tail_idx);
            RD_POS:  rd_addr = to_phys(head_reg, pos_m1);
            default: rd_addr = head_reg;
        endcase
    end

    assign wr_addr = to_phys(head_reg, pos_reg);
    assign wr_tag  = (cmd.wr_src == WR_NEW) ? tag_reg  : rd_tag;
    assign wr_prio = (cmd.wr_src == WR_NEW) ? prio_reg : rd_prio;

    spq_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_tag),
        .rd_addr (rd_addr),
        .rd_data (rd_tag)
    );

    spq_ram #(
        .WIDTH (PRIO_BITS),
        .DEPTH (DEPTH)
    ) u_prio_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_prio),
        .rd_addr (rd_addr),
        .rd_data (rd_prio)
    );

    // Status towards the controller.
    always_comb
    begin
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CW'(DEPTH));
        stat.goes_first = asc_reg ? (prio_reg < rd_prio) : (prio_reg > rd_prio);
        stat.pos_one    = (pos_reg == AW'(1));
        stat.act_pop    = (action_reg == ACT_POP);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        asc_next        = cfg_valid ? cfg_data : asc_reg;
        action_next     = action_reg;
        tag_next        = tag_reg;
        prio_next       = prio_reg;
        pos_next        = pos_reg;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;
        out_tag_next    = out_tag_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load_in)
        begin
            action_next  = action;
            tag_next     = entry_tag;
            prio_next    = entry_priority;
            pos_next     = AW'(count_reg);
            res_tag_next = '0;
            if (action == ACT_PUSH)
            begin
                res_status_next = stat.count_full ? ST_FULL : ST_OK;
            end
            else if (action == ACT_POP || action == ACT_PEEK)
            begin
                res_status_next = stat.count_zero ? ST_EMPTY : ST_OK;
            end
            else
            begin
                res_status_next = ST_OK;
            end
        end
        if (cmd.pos_dec)
        begin
            pos_next = pos_m1;
        end
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.front_load)
        begin
            res_tag_next = rd_tag;
        end
        if (cmd.pop_commit)
        begin
            head_next  = to_phys(head_reg, AW'(1));
            count_next = count_reg - CW'(1);
        end
        if (cmd.out_load)
        begin
            out_tag_next    = res_tag_reg;
            out_status_next = res_status_reg;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            asc_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            asc_reg       <= asc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        tag_reg        <= tag_next;
        prio_reg       <= prio_next;
        pos_reg        <= pos_next;
        res_tag_reg    <= res_tag_next;
        res_status_reg <= res_status_next;
        out_tag_reg    <= out_tag_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign front_tag = out_tag_reg;
    assign status    = out_status_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `SPQ_ASSERT_NOW(a_no_insert_when_full, cmd.count_inc, !stat.count_full)
    `SPQ_ASSERT_NOW(a_no_pop_when_empty, cmd.pop_commit, !stat.count_zero)
    `SPQ_ASSERT_NOW(a_shift_not_front, cmd.wr_en && cmd.wr_src == WR_SHIFT, pos_reg != '0)
    `SPQ_ASSERT_NEXT(a_result_held, cmd.out_load, out_valid_reg)

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl, spq_datapath and spq_ram.
//
// Use of the block:
// The input channel (in_valid, in_ready) takes one word per command: action
// selects push, pop or peek, and entry_tag and entry_priority carry the entry
// to be pushed. The output channel (out_valid, out_ready) returns exactly one
// word per command: front_tag and status. The configuration channel
// (cfg_valid, cfg_ready, ascending_order) sets the service order and is always
// ready; it should be written only while the queue is idle.
// Entries are held in a circular sorted store in two RAMs, so a pop only moves
// the head pointer. A push walks from the rear towards the front, moving one
// entry back per step; each step is a RAM read followed by a compare and write.
// A pop or peek of a held entry passes through a RAM read at the head, a load
// of the front tag and the result state; a dropped push, an empty pop or peek
// or an unused code goes straight to the result state. A push ends when the
// compare finds its place, or with a final insert when it reaches the front
// or the queue was empty. in_ready rises in the same cycle as the result is
// offered, even while that result still waits in the output register; if the
// receiver stalls, the following result is held back until the output
// register is free. Reset empties the queue and selects ascending order; the
// RAM contents are left as they are, and need no clearing pass.
module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::SPQ_DEPTH,
    parameter int TAG_BITS  = spq_pkg::SPQ_TAG_BITS,
    parameter int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [TAG_BITS-1:0]  entry_tag,
    input  logic [PRIO_BITS-1:0] entry_priority,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TAG_BITS-1:0]  front_tag,
    output logic [1:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 ascending_order
);
    import spq_pkg::*;

    // Commands from the controller and status back from the datapath.
    spq_cmd_t  cmd;
    spq_stat_t stat;

    // The order register is a single flop, so every write is taken at once.
    assign cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_datapath #(
        .DEPTH     (DEPTH),
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .entry_tag      (entry_tag),
        .entry_priority (entry_priority),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_data       (ascending_order),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .front_tag      (front_tag),
        .status         (status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the sorted priority queue.
// Depends on spq_pkg and the sorted_priority_queue RTL; needs no other files.
// Words are checked against a behavioural model of the queue held in this file.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int TAG_W    = SPQ_TAG_BITS;
    localparam int PRIO_W   = SPQ_PRIO_BITS;
    localparam int SETTLE   = 2 * SPQ_DEPTH + 8;
    localparam int RANDOM_WORDS = 400;

    // The action field is two bits wide, so the one code with no meaning is sent as well.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SHAPE_FILL,
        SHAPE_GROW,
        SHAPE_SHRINK,
        SHAPE_NOISE
    } shape_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        status_t          st;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        action = ACT_PUSH;
    logic [TAG_W-1:0]  entry_tag = '0;
    logic [PRIO_W-1:0] entry_priority = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [TAG_W-1:0]  front_tag;
    logic [1:0]        status;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              ascending_order = 1'b1;

    // Model of the queue: entries kept sorted, front at index 0.
    logic [TAG_W-1:0]  model_tag [SPQ_DEPTH];
    logic [PRIO_W-1:0] model_prio [SPQ_DEPTH];
    int                model_count = 0;
    bit                order_asc = 1'b1;

    result_t awaited_results [$];
    int      mismatch_count = 0;
    int      words_sent = 0;
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;
    bit      narrow_prios = 1'b0;
    int      stall_left = 0;

    sorted_priority_queue u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .entry_tag      (entry_tag),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .front_tag      (front_tag),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .ascending_order(ascending_order)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Length of an idle stretch: mostly short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic int sender_gap();
        if (tx_calm || $urandom_range(0, 99) < 55)
            return 0;
        return idle_length();
    endfunction

    function automatic logic [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (narrow_prios)
            return PRIO_W'($urandom_range(0, 3));
        return PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
    endfunction

    // True when a fresh priority must leave ahead of one already held.
    function automatic bit served_first(logic [PRIO_W-1:0] fresh, logic [PRIO_W-1:0] held);
        return order_asc ? (fresh < held) : (fresh > held);
    endfunction

    // Applies one accepted word to the model and queues the result it must give.
    task automatic predict_word(input logic [1:0] act, input logic [TAG_W-1:0] tag,
                                input logic [PRIO_W-1:0] prio);
        result_t r;
        int      pos;
        r.tag = '0;
        r.st  = ST_OK;
        case (act)
            ACT_PUSH:
            begin
                if (model_count >= SPQ_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    // Search from the rear so that equal priorities keep arrival order.
                    pos = model_count;
                    while (pos > 0 && served_first(prio, model_prio[pos-1]))
                    begin
                        model_tag[pos]  = model_tag[pos-1];
                        model_prio[pos] = model_prio[pos-1];
                        pos--;
                    end
                    model_tag[pos]  = tag;
                    model_prio[pos] = prio;
                    model_count++;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (model_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.tag = model_tag[0];
                    if (act == ACT_POP)
                    begin
                        for (pos = 0; pos + 1 < model_count; pos++)
                        begin
                            model_tag[pos]  = model_tag[pos+1];
                            model_prio[pos] = model_prio[pos+1];
                        end
                        model_count--;
                    end
                end
            end
            default:
                ;
        endcase
        awaited_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sends one word; valid stays high after acceptance until the next call or a drain.
    task automatic send_word(input logic [1:0] act, input logic [TAG_W-1:0] tag,
                             input logic [PRIO_W-1:0] prio);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        entry_tag      <= tag;
        entry_priority <= prio;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        predict_word(act, tag, prio);
        words_sent++;
    endtask

    // Lowers valid and waits until every result is back and the block has settled.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_order(input bit asc);
        wait_idle();
        @(negedge clk);
        cfg_valid       <= 1'b1;
        ascending_order <= asc;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        order_asc = asc;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_push();
        send_word(ACT_PUSH, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)), pick_priority());
    endtask

    // Pop, peek and the spare code on a queue that has just come out of reset.
    task automatic test_empty_queue();
        send_word(ACT_POP, '0, '0);
        send_word(ACT_PEEK, '1, '1);
        send_word(ACT_SPARE, '1, '1);
    endtask

    // Extreme tags and priorities in the reset order, with a tie on priority zero.
    task automatic test_ascending_extremes();
        send_word(ACT_PUSH, 8'hFF, 8'h00);
        send_word(ACT_PUSH, 8'h00, 8'hFF);
        send_word(ACT_PUSH, 8'hA5, 8'h00);
        send_word(ACT_PUSH, 8'h5A, 8'h80);
        send_word(ACT_PEEK, '0, '0);
        send_word(ACT_SPARE, 8'h33, 8'hCC);
        send_word(ACT_POP, '0, '0);
        send_word(ACT_POP, '0, '0);
    endtask

    // The order flips while two entries are still held; they must keep their places.
    task automatic test_order_change();
        write_order(1'b0);
        send_word(ACT_PUSH, 8'h3C, 8'h80);
        send_word(ACT_PUSH, 8'hC3, 8'hFF);
        repeat (4) send_word(ACT_POP, '0, '0);
        send_word(ACT_POP, '0, '0);
        write_order(1'b1);
    endtask

    // Phases of random traffic, each under its own order and idling pattern.
    task automatic test_random_traffic();
        int     start_count;
        int     length;
        int     r;
        shape_t shape;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            write_order($urandom_range(0, 1));
            tx_calm      = ($urandom_range(0, 3) == 0);
            rx_calm      = ($urandom_range(0, 3) == 0);
            narrow_prios = ($urandom_range(0, 1) == 0);
            shape        = shape_t'($urandom_range(0, 3));
            length       = $urandom_range(10, 40);
            case (shape)
                SHAPE_FILL:
                begin
                    // Fill to the brim, overflow it, then empty it and read once more.
                    while (model_count < SPQ_DEPTH)
                        random_push();
                    repeat ($urandom_range(1, 3)) random_push();
                    send_word(ACT_PEEK, '0, '0);
                    while (model_count > 0)
                        send_word(ACT_POP, '0, '0);
                    send_word(ACT_POP, '0, '0);
                end
                default:
                begin
                    repeat (length)
                    begin
                        r = $urandom_range(0, 99);
                        if (shape == SHAPE_NOISE)
                            send_word(2'($urandom_range(0, 3)),
                                      TAG_W'($urandom_range(0, (1 << TAG_W) - 1)),
                                      pick_priority());
                        else if (r < (shape == SHAPE_GROW ? 70 : 25))
                            random_push();
                        else if (r < (shape == SHAPE_GROW ? 85 : 85))
                            send_word(ACT_POP, TAG_W'($urandom), pick_priority());
                        else if (r < 97)
                            send_word(ACT_PEEK, TAG_W'($urandom), pick_priority());
                        else
                            send_word(ACT_SPARE, TAG_W'($urandom), pick_priority());
                    end
                end
            endcase
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // The receiver stalls at random, or not at all while rx_calm is set.
    always @(negedge clk)
    begin
        if (rx_calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = idle_length();
        end
    end

    // Every result word is compared with the oldest one still awaited.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result word with none awaited");
            else
            begin
                want = awaited_results.pop_front();
                if (front_tag !== want.tag)
                    report_mismatch($sformatf("front_tag %0h, wanted %0h", front_tag, want.tag));
                if (status !== want.st)
                    report_mismatch($sformatf("status field %0d, wanted %0d", status, want.st));
            end
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_queue();
        test_ascending_extremes();
        test_order_change();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue.sv
bench/tb_top.sv
